// ----- rtl/core/jsu_pkg.sv -----
// ============================================================================
// JSON string unescape: shared types
// Status codes and the decoded-entry record passed from the front part
// through the queue to the back part.
// ============================================================================
package jsu_pkg;

  // Status of a result item.
  typedef enum logic [1:0] {
    ST_BUSY      = 2'd0,
    ST_DONE      = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  // One classified input byte: up to three decoded bytes and the shared
  // status and consumed count of the results it causes.
  typedef struct packed {
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [1:0]  last_idx;
    logic        has_byte;
    status_e     status;
    logic [15:0] consumed;
  } jsu_entry_t;

endpackage

// ----- rtl/core/jsu_front.sv -----
// ============================================================================
// JSON string unescape: front part
// Holds the capacity register and the parsing state, and turns each
// accepted raw byte into one queue entry.
// ============================================================================
module jsu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  output jsu_pkg::jsu_entry_t entry_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_e;

  localparam logic [7:0]  ChQuote  = 8'h22;
  localparam logic [7:0]  ChBslash = 8'h5c;
  localparam logic [7:0]  ChSlash  = 8'h2f;
  localparam logic [7:0]  ChB      = 8'h62;
  localparam logic [7:0]  ChF      = 8'h66;
  localparam logic [7:0]  ChN      = 8'h6e;
  localparam logic [7:0]  ChR      = 8'h72;
  localparam logic [7:0]  ChT      = 8'h74;
  localparam logic [7:0]  ChU      = 8'h75;
  localparam logic [7:0]  ChDel    = 8'h7f;
  localparam logic [7:0]  ChSpace  = 8'h20;
  localparam logic [15:0] Max1Byte = 16'h007f;
  localparam logic [15:0] Max2Byte = 16'h07ff;
  localparam logic [7:0]  Lead2    = 8'hc0;
  localparam logic [7:0]  Lead3    = 8'he0;
  localparam logic [7:0]  ContMark = 8'h80;
  localparam logic [7:0]  ContMask = 8'h3f;
  localparam logic [15:0] CapReset = 16'd8192;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [15:0] accum_q, accum_d;
  logic [15:0] consumed_q, consumed_d;
  logic [15:0] written_q, written_d;
  logic [15:0] capacity_q;

  logic [15:0] cons_inc;
  logic [4:0]  nib;
  logic [15:0] cp;
  logic [1:0]  need;
  logic        room1;
  logic        room_cp;
  logic        emit_plain;
  logic [7:0]  plain_b;
  jsu_entry_t  entry;

  assign cons_inc = (consumed_q == 16'hffff) ? consumed_q : consumed_q + 16'd1;
  assign nib      = hex_nibble(in_byte_i);
  assign cp       = {accum_q[11:0], nib[3:0]};
  assign need     = (cp <= Max1Byte) ? 2'd1 : (cp <= Max2Byte) ? 2'd2 : 2'd3;
  assign room1    = ({1'b0, written_q} + 17'd1) <= {1'b0, capacity_q};
  assign room_cp  = ({1'b0, written_q} + {15'd0, need}) <= {1'b0, capacity_q};

  // Phase transition and entry formation for the byte on the input.
  always_comb begin
    phase_d    = phase_q;
    accum_d    = accum_q;
    consumed_d = cons_inc;
    written_d  = written_q;
    emit_plain = 1'b0;
    plain_b    = in_byte_i;
    entry          = '0;
    entry.status   = ST_BUSY;
    entry.consumed = cons_inc;

    unique case (phase_q)
      PH_IDLE: begin
        if (in_byte_i != ChQuote) begin
          consumed_d     = consumed_q;
          entry.consumed = consumed_q;
          entry.status   = ST_MALFORMED;
        end else begin
          consumed_d     = 16'd1;
          entry.consumed = 16'd1;
          written_d      = 16'd0;
          accum_d        = 16'd0;
          phase_d        = PH_STR;
        end
      end
      PH_STR: begin
        if (in_byte_i == ChQuote) begin
          phase_d      = PH_IDLE;
          entry.status = room1 ? ST_DONE : ST_OVERFLOW;
        end else if (in_byte_i == ChBslash) begin
          phase_d = PH_ESC;
        end else if (in_byte_i < ChSpace || in_byte_i == ChDel) begin
          phase_d      = PH_IDLE;
          entry.status = ST_MALFORMED;
        end else begin
          emit_plain = 1'b1;
        end
      end
      PH_ESC: begin
        phase_d    = PH_STR;
        emit_plain = 1'b1;
        case (in_byte_i)
          ChQuote, ChBslash, ChSlash: plain_b = in_byte_i;
          ChB:     plain_b = 8'h08;
          ChF:     plain_b = 8'h0c;
          ChN:     plain_b = 8'h0a;
          ChR:     plain_b = 8'h0d;
          ChT:     plain_b = 8'h09;
          ChU: begin
            emit_plain = 1'b0;
            accum_d    = 16'd0;
            phase_d    = PH_HEX1;
          end
          default: begin
            emit_plain   = 1'b0;
            phase_d      = PH_IDLE;
            entry.status = ST_MALFORMED;
          end
        endcase
      end
      PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (!nib[4]) begin
          phase_d      = PH_IDLE;
          entry.status = ST_MALFORMED;
        end else begin
          accum_d = cp;
          if (phase_q == PH_HEX1) begin
            phase_d = PH_HEX2;
          end else if (phase_q == PH_HEX2) begin
            phase_d = PH_HEX3;
          end else begin
            phase_d = PH_HEX4;
          end
        end
      end
      PH_HEX4: begin
        if (!nib[4]) begin
          phase_d      = PH_IDLE;
          entry.status = ST_MALFORMED;
        end else if (!room_cp) begin
          accum_d      = cp;
          phase_d      = PH_IDLE;
          entry.status = ST_OVERFLOW;
        end else begin
          // Encode the code unit as one to three UTF-8 bytes.
          accum_d        = cp;
          phase_d        = PH_STR;
          written_d      = written_q + {14'd0, need};
          entry.has_byte = 1'b1;
          entry.last_idx = need - 2'd1;
          if (need == 2'd1) begin
            entry.byte0 = cp[7:0];
          end else if (need == 2'd2) begin
            entry.byte0 = Lead2 | {3'd0, cp[10:6]};
            entry.byte1 = ContMark | (cp[7:0] & ContMask);
          end else begin
            entry.byte0 = Lead3 | {4'd0, cp[15:12]};
            entry.byte1 = ContMark | ({2'd0, cp[11:6]} & ContMask);
            entry.byte2 = ContMark | (cp[7:0] & ContMask);
          end
        end
      end
      default: begin
        phase_d      = PH_IDLE;
        entry.status = ST_MALFORMED;
      end
    endcase

    // A single data byte needs room for itself.
    if (emit_plain) begin
      if (room1) begin
        written_d      = written_q + 16'd1;
        entry.has_byte = 1'b1;
        entry.byte0    = plain_b;
      end else begin
        phase_d      = PH_IDLE;
        entry.status = ST_OVERFLOW;
      end
    end
  end

  assign entry_o = entry;

  // Parsing state and capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      accum_q    <= 16'd0;
      consumed_q <= 16'd0;
      written_q  <= 16'd0;
      capacity_q <= CapReset;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_data_i;
      end
      if (accept_i) begin
        phase_q    <= phase_d;
        accum_q    <= accum_d;
        consumed_q <= consumed_d;
        written_q  <= written_d;
      end
    end
  end

endmodule

// ----- rtl/core/jsu_fifo.sv -----
// ============================================================================
// JSON string unescape: entry queue
// Short first-in first-out queue of decoded entries between the front
// and the back part.
// ============================================================================
module jsu_fifo #(
  parameter int Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jsu_pkg::jsu_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                empty_o,
  output jsu_pkg::jsu_entry_t head_o
);
  import jsu_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr  = AW'(Depth - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(Depth);

  jsu_entry_t    mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == DepthCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Entry storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/jsu_back.sv -----
// ============================================================================
// JSON string unescape: back part
// Walks the bytes of the head entry, one result transfer per byte, and
// releases the entry after its final result.
// ============================================================================
module jsu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jsu_pkg::jsu_entry_t head_i,
  input  logic                empty_i,
  input  logic                pop_i,
  output logic                fifo_pop_o,
  output logic [7:0]          out_byte_o,
  output logic                byte_valid_o,
  output logic [1:0]          status_o,
  output logic [15:0]         consumed_o,
  output logic                last_o
);
  import jsu_pkg::*;

  logic [1:0] idx_q;
  logic       take;

  assign take       = pop_i && !empty_i;
  assign last_o     = (idx_q == head_i.last_idx);
  assign fifo_pop_o = take && last_o;

  // Pick the byte of the entry that is due next.
  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = head_i.byte0;
      2'd1:    out_byte_o = head_i.byte1;
      default: out_byte_o = head_i.byte2;
    endcase
  end

  assign byte_valid_o = head_i.has_byte;
  assign status_o     = head_i.status;
  assign consumed_o   = head_i.consumed;

  // Byte index within the head entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (take) begin
      idx_q <= last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

// ----- rtl/core/json_string_unescape.sv -----
// ============================================================================
// JSON string unescape
// Decodes one quoted JSON string, byte by byte, into raw and UTF-8 bytes.
// ============================================================================
// The block takes one raw byte per cycle, starting with the opening quote,
// and queues one entry per byte holding up to three decoded bytes. Result
// transfers leave one per cycle while pop is high; a \u escape that encodes
// to two or three UTF-8 bytes holds the output side for one transfer per
// byte, and a queue of QueueDepth entries between the parser and the output
// side absorbs such bursts, so input is taken every cycle while the queue has
// room. Every input byte causes at least one result, the last of which has
// last set. The capacity register may be written at any cycle; it takes
// effect for the next input byte. There is no start-up clearing pass.
module json_string_unescape #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] consumed_o,
  output logic        last_o
);
  import jsu_pkg::*;

  jsu_entry_t entry;
  jsu_entry_t head;
  logic       accept;
  logic       fifo_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Parser and capacity register.
  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .entry_o    (entry)
  );

  // Queue between parser and output side.
  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .entry_i (entry),
    .pop_i   (fifo_pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // Output side, one result per decoded byte, or one for an entry without a byte.
  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_i        (pop),
    .fifo_pop_o   (fifo_pop),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .status_o     (status_o),
    .consumed_o   (consumed_o),
    .last_o       (last_o)
  );

  // A finished or failed result never carries a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_BUSY) |-> !byte_valid_o)
    else $error("result with final status carries a byte");

  // Results without a byte are always single results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !byte_valid_o) |-> last_o)
    else $error("byte-less result is not the last of its input");

  // After a non-final result transfer the rest of the burst is still there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_o) |=> !empty)
    else $error("burst lost after a non-final result transfer");

  // A full queue always presents a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("queue reports full and empty together");

endmodule

// ----- dv/tb_json_string_unescape.sv -----
// ============================================================================
// JSON string unescape: self-checking testbench
// Feeds quoted JSON strings into the block one byte per transfer and checks
// each result transfer against a predictor of the decoder kept in this file.
// A short table of hand-picked bytes comes first, followed by random strings
// under several capacity settings and handshake idling patterns.
// ============================================================================
module tb_json_string_unescape;
  import jsu_pkg::*;

  // Characters and UTF-8 framing used by the decoder.
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7f;
  localparam logic [7:0] CH_TILDE   = 8'h7e;
  localparam logic [7:0] CH_BKSP    = 8'h08;
  localparam logic [7:0] CH_FEED    = 8'h0c;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_U       = "u";
  localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0] UTF8_LEAD3 = 8'he0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [15:0] ONE_BYTE_MAX = 16'h007f;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07ff;
  localparam int unsigned CAP_RESET = 8192;
  localparam int unsigned CAP_MAX   = 65535;

  // Parser position of the predictor.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TEXT,
    PH_ESCAPE,
    PH_HEX
  } parse_phase_e;

  // One result transfer.
  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    status_e     status;
    logic [15:0] consumed;
    logic        last;
  } result_t;

  // One row of the directed table: a capacity write or an input byte, with
  // an optional hand-written expectation.
  typedef struct {
    bit          is_cfg;
    logic [15:0] data;
    bit          typed;
    result_t     want;
  } step_row_t;

  localparam result_t NONE = '{8'h00, 1'b0, ST_BUSY, 16'd0, 1'b0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic [1:0]  status_o;
  logic [15:0] consumed_o;
  logic        last_o;

  json_string_unescape dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .in_byte_i    (in_byte_i),
    .empty        (empty),
    .pop          (pop),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .status_o     (status_o),
    .consumed_o   (consumed_o),
    .last_o       (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state, starting from the reset values.
  parse_phase_e m_phase = PH_IDLE;
  logic [15:0]  m_code = '0;
  logic [15:0]  m_consumed = '0;
  int           m_written = 0;
  int           m_hex_left = 0;
  int           m_capacity = CAP_RESET;

  result_t decoded_q[$];
  int      errors = 0;
  int      items_sent = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 30;
  int      rx_hold = 0;
  bit      offering = 0;

  logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r", "t"};

  // Hand-picked bytes: errors at idle, byte extremes, \u escapes of three and
  // two UTF-8 bytes, a NUL byte, an unknown escape and tiny capacities.
  step_row_t directed [28] = '{
    '{0, "x",       1, '{8'h00, 1'b0, ST_MALFORMED, 16'd0, 1'b1}},
    '{0, CH_QUOTE,  1, '{8'h00, 1'b0, ST_BUSY,      16'd1, 1'b1}},
    '{0, 16'h00ff,  1, '{8'hff, 1'b1, ST_BUSY,      16'd2, 1'b1}},
    '{0, CH_BSLASH, 0, NONE},
    '{0, CH_U,      0, NONE},
    '{0, "F",       0, NONE},
    '{0, "f",       0, NONE},
    '{0, "F",       0, NONE},
    '{0, "f",       0, NONE},
    '{0, CH_BSLASH, 0, NONE},
    '{0, CH_U,      0, NONE},
    '{0, "0",       0, NONE},
    '{0, "7",       0, NONE},
    '{0, "f",       0, NONE},
    '{0, "F",       0, NONE},
    '{0, CH_QUOTE,  1, '{8'h00, 1'b0, ST_DONE,      16'd15, 1'b1}},
    '{0, CH_QUOTE,  0, NONE},
    '{0, 16'h0000,  1, '{8'h00, 1'b0, ST_MALFORMED, 16'd2, 1'b1}},
    '{0, CH_QUOTE,  0, NONE},
    '{0, CH_BSLASH, 0, NONE},
    '{0, "q",       1, '{8'h00, 1'b0, ST_MALFORMED, 16'd3, 1'b1}},
    '{1, 16'd0,     0, NONE},
    '{0, CH_QUOTE,  0, NONE},
    '{0, CH_QUOTE,  1, '{8'h00, 1'b0, ST_OVERFLOW,  16'd2, 1'b1}},
    '{1, 16'd1,     0, NONE},
    '{0, CH_QUOTE,  0, NONE},
    '{0, "a",       0, NONE},
    '{0, "a",       1, '{8'h00, 1'b0, ST_OVERFLOW,  16'd3, 1'b1}}
  };

  // Queue one expected result carrying the current consumed count.
  task automatic emit(input logic [7:0] data, input logic valid, input status_e st,
                      input logic last);
    decoded_q.push_back('{data, valid, st, m_consumed, last});
  endtask

  // An error ends the string and sends the parser back to idle.
  task automatic reject(input status_e st);
    m_phase = PH_IDLE;
    emit(8'h00, 1'b0, st, 1'b1);
  endtask

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - CH_ZERO);
    if (c >= "a" && c <= "f") return int'(c - CH_LOWER_A) + 10;
    if (c >= "A" && c <= "F") return int'(c - CH_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return CH_ZERO + v;
    return (upper ? CH_UPPER_A : CH_LOWER_A) + (v - 4'd10);
  endfunction

  // Work out the results that one accepted input byte causes.
  task automatic decode_byte(input logic [7:0] c);
    logic [7:0]  b;
    logic [15:0] cp;
    int          n;
    int          h;
    if (m_phase == PH_IDLE) begin
      if (c != CH_QUOTE) begin
        reject(ST_MALFORMED);
        return;
      end
      m_consumed = 16'd1;
      m_written = 0;
      m_code = '0;
      m_phase = PH_TEXT;
      emit(8'h00, 1'b0, ST_BUSY, 1'b1);
      return;
    end
    if (m_consumed != 16'hffff) m_consumed++;
    case (m_phase)
      PH_TEXT: begin
        // The closing quote needs room for the terminator.
        if (c == CH_QUOTE) begin
          if (m_written + 1 > m_capacity) begin
            reject(ST_OVERFLOW);
          end else begin
            m_phase = PH_IDLE;
            emit(8'h00, 1'b0, ST_DONE, 1'b1);
          end
          return;
        end
        if (c == CH_BSLASH) begin
          m_phase = PH_ESCAPE;
          emit(8'h00, 1'b0, ST_BUSY, 1'b1);
          return;
        end
        if (c < CH_SPACE || c == CH_DEL) begin
          reject(ST_MALFORMED);
          return;
        end
        b = c;
      end
      PH_ESCAPE: begin
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: b = c;
          "b": b = CH_BKSP;
          "f": b = CH_FEED;
          "n": b = CH_LF;
          "r": b = CH_CR;
          "t": b = CH_TAB;
          CH_U: begin
            m_code = '0;
            m_hex_left = 4;
            m_phase = PH_HEX;
            emit(8'h00, 1'b0, ST_BUSY, 1'b1);
            return;
          end
          default: begin
            reject(ST_MALFORMED);
            return;
          end
        endcase
        m_phase = PH_TEXT;
      end
      default: begin
        h = hex_val(c);
        if (h < 0) begin
          reject(ST_MALFORMED);
          return;
        end
        m_code = {m_code[11:0], h[3:0]};
        m_hex_left--;
        if (m_hex_left != 0) begin
          emit(8'h00, 1'b0, ST_BUSY, 1'b1);
          return;
        end
        // Fourth digit: encode the code unit on its own as UTF-8.
        cp = m_code;
        n = (cp <= ONE_BYTE_MAX) ? 1 : (cp <= TWO_BYTE_MAX) ? 2 : 3;
        if (m_written + n > m_capacity) begin
          reject(ST_OVERFLOW);
          return;
        end
        m_written += n;
        m_phase = PH_TEXT;
        case (n)
          1: emit(cp[7:0], 1'b1, ST_BUSY, 1'b1);
          2: begin
            emit(UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b1, ST_BUSY, 1'b0);
            emit(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, ST_BUSY, 1'b1);
          end
          default: begin
            emit(UTF8_LEAD3 | {4'h0, cp[15:12]}, 1'b1, ST_BUSY, 1'b0);
            emit(UTF8_CONT | {2'b00, cp[11:6]}, 1'b1, ST_BUSY, 1'b0);
            emit(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, ST_BUSY, 1'b1);
          end
        endcase
        return;
      end
    endcase
    // A plain or simply escaped byte.
    if (m_written + 1 > m_capacity) begin
      reject(ST_OVERFLOW);
      return;
    end
    m_written++;
    emit(b, 1'b1, ST_BUSY, 1'b1);
  endtask

  task automatic stop_offering();
    if (offering) begin
      push <= 1'b0;
      offering = 0;
    end
  endtask

  // Offer one byte, possibly after a gap, and wait for its transfer.
  task automatic send_byte(input logic [7:0] b);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      stop_offering();
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_byte_i <= b;
    offering = 1;
    do @(posedge clk_i); while (full);
    decode_byte(b);
    items_sent++;
  endtask

  // Only keep feeding a string while the parser is still inside it.
  task automatic send_in_string(input logic [7:0] b);
    if (m_phase != PH_IDLE) send_byte(b);
  endtask

  // Stop offering input and wait until every expected result has come.
  task automatic wait_drained();
    stop_offering();
    do @(posedge clk_i); while (decoded_q.size() != 0);
  endtask

  task automatic set_capacity(input logic [15:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    m_capacity = v;
  endtask

  function automatic logic [7:0] rand_text();
    logic [7:0] v;
    do v = $urandom_range(CH_SPACE, CH_TILDE); while (v == CH_QUOTE || v == CH_BSLASH);
    return v;
  endfunction

  // One random piece of string content, mostly well formed.
  task automatic send_token();
    int          r;
    logic [15:0] code;
    int          good;
    r = $urandom_range(99);
    if (r < 38) begin
      send_in_string(rand_text());
    end else if (r < 50) begin
      send_in_string(8'h80 + 8'($urandom_range(127)));
    end else if (r < 64) begin
      send_in_string(CH_BSLASH);
      send_in_string(esc_letters[$urandom_range(7)]);
    end else if (r < 84) begin
      case ($urandom_range(2))
        0: code = 16'($urandom_range(0, ONE_BYTE_MAX));
        1: code = 16'($urandom_range(ONE_BYTE_MAX + 1, TWO_BYTE_MAX));
        default: code = 16'($urandom_range(TWO_BYTE_MAX + 1, 16'hffff));
      endcase
      send_in_string(CH_BSLASH);
      send_in_string(CH_U);
      for (int d = 3; d >= 0; d--) begin
        send_in_string(hex_char(code[4*d +: 4], 1'($urandom_range(1))));
      end
    end else if (r < 89) begin
      // Control byte inside the string.
      send_in_string($urandom_range(1) ? CH_DEL : 8'($urandom_range(0, 8'h1f)));
    end else if (r < 93) begin
      send_in_string(CH_BSLASH);
      send_in_string(8'($urandom_range(255)));
    end else if (r < 97) begin
      // A \u escape with up to three hex digits, followed by an arbitrary byte.
      good = $urandom_range(3);
      send_in_string(CH_BSLASH);
      send_in_string(CH_U);
      for (int d = 0; d < good; d++) send_in_string(hex_char(4'($urandom_range(15)), 1'b0));
      send_in_string(8'($urandom_range(255)));
    end else begin
      send_in_string(8'($urandom_range(255)));
    end
  endtask

  task automatic send_string(input int max_len);
    int len;
    if ($urandom_range(99) < 5) send_byte(8'($urandom_range(255)));
    send_byte(CH_QUOTE);
    len = $urandom_range(max_len);
    for (int i = 0; i < len && m_phase != PH_IDLE; i++) send_token();
    if ($urandom_range(99) < 93) send_in_string(CH_QUOTE);
  endtask

  // Receiver: random pop, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte %0h status %0d", out_byte_o, status_o);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte_o);
          errors++;
        end
        if (byte_valid_o !== want.valid) begin
          $error("byte_valid: expected %0d, got %0d", want.valid, byte_valid_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (consumed_o !== want.consumed) begin
          $error("consumed: expected %0d, got %0d", want.consumed, consumed_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          errors++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int target;
    int max_len;
    bit paused;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed rows replace the predicted result.
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        set_capacity(directed[i].data);
      end else begin
        send_byte(directed[i].data[7:0]);
        if (directed[i].typed) begin
          void'(decoded_q.pop_back());
          decoded_q.push_back(directed[i].want);
        end
      end
    end

    // Random strings under several capacities and idling patterns.
    for (int p = 0; p < 6; p++) begin
      tx_idle_pct = (p < 2) ? 17 : (p < 4) ? 64 : 0;
      rx_idle_pct = (p < 2) ? 64 : (p < 4) ? 17 : 0;
      case (p)
        0: set_capacity(16'(CAP_MAX));
        1: set_capacity(16'd1);
        2: set_capacity(16'd2);
        3: set_capacity(16'(CAP_RESET));
        4: set_capacity(16'($urandom_range(3, 24)));
        default: set_capacity(16'($urandom_range(25, 400)));
      endcase
      // Hold the output side so the block fills up and stalls its input.
      if (p == 3) rx_hold = 300;
      paused = 0;
      target = items_sent + 68;
      while (items_sent < target) begin
        if (p == 4 && !paused && items_sent > target - 40) begin
          wait_drained();
          paused = 1;
        end
        max_len = ($urandom_range(99) < 10) ? 24 : 8;
        send_string(max_len);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Give up well past the slowest correct run.
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
